>>> rtl/addressable_led_spi_frame_encoder_defines.svh
// assertion macros for the addressable led spi frame encoder
`ifndef ADDRESSABLE_LED_SPI_FRAME_ENCODER_DEFINES_SVH
`define ADDRESSABLE_LED_SPI_FRAME_ENCODER_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define ALSFE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property that must hold in the cycle after its trigger
`define ALSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/alsfe_pkg.sv
// shared types, command codes and symbol coding for the led spi frame encoder
`default_nettype none
package alsfe_pkg;

  localparam logic [1:0] CMD_PIXEL       = 2'd0;
  localparam logic [1:0] CMD_FRAME_START = 2'd1;
  localparam logic [1:0] CMD_FRAME_END   = 2'd2;

  localparam logic [2:0] SYM_ZERO = 3'b100;
  localparam logic [2:0] SYM_ONE  = 3'b110;

  localparam int unsigned WORD_W      = 24;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [8:0]  SCALE_FULL  = 9'd256;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic       pad;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } entry_t;

  function automatic logic [WORD_W-1:0] encode_channel(input logic [7:0] c);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      w[3*k +: 3] = c[k] ? SYM_ONE : SYM_ZERO;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/alsfe_front.sv
// front end: takes items, dims and blanks colors, holds one classified entry
`default_nettype none
module alsfe_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [1:0]       cmd,
  input  wire logic [7:0]       red,
  input  wire logic [7:0]       green,
  input  wire logic [7:0]       blue,
  input  wire logic             lit,
  input  wire logic             use_scale,
  input  wire logic [8:0]       scale,
  input  wire logic             strip_enable,
  output logic                  stage_valid,
  output alsfe_pkg::entry_t     stage,
  input  wire logic             q_ready
);
  import alsfe_pkg::*;

  logic        accept;
  logic        keep;
  logic        dark;
  logic [8:0]  scale_sat;
  logic [16:0] prod_g, prod_r, prod_b;
  entry_t      entry;

  assign full   = stage_valid & ~q_ready;
  assign accept = push & ~full;

  assign dark      = ~lit | ~strip_enable;
  assign scale_sat = (scale > SCALE_FULL) ? SCALE_FULL : scale;
  assign prod_g    = {9'd0, green} * {8'd0, scale_sat};
  assign prod_r    = {9'd0, red}   * {8'd0, scale_sat};
  assign prod_b    = {9'd0, blue}  * {8'd0, scale_sat};

  always_comb begin
    entry = '0;
    keep  = 1'b0;
    unique case (cmd) inside
      CMD_PIXEL: begin
        keep      = 1'b1;
        entry.pad = 1'b0;
        if (!dark) begin
          entry.green = use_scale ? prod_g[15:8] : green;
          entry.red   = use_scale ? prod_r[15:8] : red;
          entry.blue  = use_scale ? prod_b[15:8] : blue;
        end
      end
      CMD_FRAME_START, CMD_FRAME_END: begin
        keep      = 1'b1;
        entry.pad = 1'b1;
      end
      // unused code gives no words
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= keep;
    end else if (q_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= entry;
    end
  end

endmodule
`default_nettype wire

>>> rtl/alsfe_queue.sv
// small register queue between front and back
`default_nettype none
module alsfe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire alsfe_pkg::entry_t wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output alsfe_pkg::entry_t      rd_data
);
  import alsfe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid & wr_ready;
  assign do_rd    = rd_valid & rd_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!do_wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/alsfe_back.sv
// back end: walks each entry word by word into the output register
`default_nettype none
module alsfe_back #(
  parameter int unsigned PAD_WORDS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire alsfe_pkg::entry_t q_data,
  output logic                   empty,
  input  wire logic              pop,
  output logic [23:0]            spi_word,
  output logic                   last
);
  import alsfe_pkg::*;

  localparam int unsigned CNT_W = (PAD_WORDS > 4) ? $clog2(PAD_WORDS) : 2;

  logic             out_valid;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic             load;
  logic             entry_last;
  logic [7:0]       chan;
  logic [23:0]      word_next;

  assign empty      = ~out_valid;
  assign load       = q_valid & (~out_valid | pop);
  assign entry_last = q_data.pad ? (idx == CNT_W'(PAD_WORDS - 1)) : (idx == CNT_W'(2));
  assign q_pop      = load & entry_last;

  // green, red, blue order on the wire
  always_comb begin
    case (idx[1:0])
      2'd0:    chan = q_data.green;
      2'd1:    chan = q_data.red;
      default: chan = q_data.blue;
    endcase
  end

  assign word_next = q_data.pad ? '0 : encode_channel(chan);

  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = entry_last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      spi_word <= word_next;
      last     <= entry_last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/addressable_led_spi_frame_encoder.sv
// top level of the addressable led spi frame encoder
`default_nettype none
`include "addressable_led_spi_frame_encoder_defines.svh"
// Each pixel item becomes three 24-bit spi beats (green, red, blue, each channel
// coded as 3-bit symbols 100/110 msb first); a frame start or frame end item
// becomes PAD_WORDS all-zero beats, the strip reset gap. last marks the final
// beat of each item. The back end emits one beat per cycle while the queue has
// an entry and the result side pops; the front end takes an item per cycle
// while full is low into a 4-entry queue and runs ahead while the back end or
// the result side stalls. On its way to the first beat an item passes the
// dimming multiply stage, the queue and the output register. Cmd 3 items are
// taken and dropped. strip_enable is written through cfg_valid/cfg_data and
// should only change while no item is in flight.
module addressable_led_spi_frame_encoder #(
  parameter int unsigned PAD_WORDS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic        lit,
  input  wire logic        use_scale,
  input  wire logic [8:0]  scale,
  output logic             empty,
  input  wire logic        pop,
  output logic [23:0]      spi_word,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import alsfe_pkg::*;

  logic   strip_enable;
  logic   stage_valid;
  entry_t stage;
  logic   q_ready;
  logic   q_valid;
  logic   q_pop;
  entry_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      strip_enable <= cfg_data;
    end
  end

  alsfe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .lit          (lit),
    .use_scale    (use_scale),
    .scale        (scale),
    .strip_enable (strip_enable),
    .stage_valid  (stage_valid),
    .stage        (stage),
    .q_ready      (q_ready)
  );

  alsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (stage_valid),
    .wr_ready (q_ready),
    .wr_data  (stage),
    .rd_valid (q_valid),
    .rd_ready (q_pop),
    .rd_data  (q_data)
  );

  alsfe_back #(
    .PAD_WORDS (PAD_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .empty    (empty),
    .pop      (pop),
    .spi_word (spi_word),
    .last     (last)
  );

  // a dark pixel lands in the front stage with all channels zero
  `ALSFE_ASSERT_NEXT(a_dark_pixel, push && !full && cmd == CMD_PIXEL && (!strip_enable || !lit), stage_valid && stage.green == 8'd0 && stage.red == 8'd0 && stage.blue == 8'd0, "dark pixel left a lit channel")
  // an unused command leaves nothing behind in the front stage
  `ALSFE_ASSERT_NEXT(a_drop_unused, push && !full && cmd != CMD_PIXEL && cmd != CMD_FRAME_START && cmd != CMD_FRAME_END, !stage_valid, "unused command was kept")
  // a stalled front entry stays put until the queue takes it
  `ALSFE_ASSERT_NEXT(a_stage_hold, stage_valid && !q_ready, stage_valid && $stable(stage), "front entry changed while queue full")
  // the back end only retires a queue entry on its final beat
  `ALSFE_ASSERT_NEXT(a_retire_last, q_pop, !empty && last, "queue entry retired without a last beat")

endmodule
`default_nettype wire

>>> tb/sv/addressable_led_spi_frame_encoder_tb.sv
// testbench for the addressable led spi frame encoder: directed table, random phases, scoreboard
`timescale 1ns / 100ps
module addressable_led_spi_frame_encoder_tb;
  import alsfe_pkg::*;

  localparam int unsigned PAD_WORDS = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [23:0] W_DARK = 24'h924924;
  localparam logic [23:0] W_FULL = 24'hDB6DB6;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 56;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       lit;
    logic       use_scale;
    logic [8:0] scale;
  } led_item_t;

  typedef struct {
    row_kind_t   kind;
    logic        enable;
    led_item_t   item;
    logic        typed;
    logic [23:0] typed_word [3];
  } table_row_t;

  typedef struct {
    logic [23:0] word;
    logic        last;
  } spi_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [1:0]  cmd = '0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic        lit = 1'b0;
  logic        use_scale = 1'b0;
  logic [8:0]  scale = '0;
  logic        pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        full;
  logic        empty;
  logic [23:0] spi_word;
  logic        last;
  logic        cfg_ready;

  spi_beat_t  pending_beats [$];
  table_row_t dir_rows [$];
  logic       strip_on = 1'b0;
  bit         quiet_tx = 1'b0;
  bit         quiet_rx = 1'b0;
  int unsigned mismatches = 0;
  int unsigned beats_checked = 0;
  int unsigned n_pixel = 0;
  int unsigned n_pad = 0;
  int unsigned n_dropped = 0;
  int unsigned cfg_writes = 0;

  addressable_led_spi_frame_encoder #(.PAD_WORDS(PAD_WORDS)) u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .red(red), .green(green),
    .blue(blue), .lit(lit), .use_scale(use_scale), .scale(scale), .empty(empty), .pop(pop),
    .spi_word(spi_word), .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats still expected", pending_beats.size());
    $display("** addressable_led_spi_frame_encoder: FAILED **");
    $finish;
  end

  function automatic int unsigned sender_gap();
    return quiet_tx ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic int unsigned receiver_gap();
    return quiet_rx ? 0 : $urandom_range(0, 10);
  endfunction

  // 3-bit symbol per channel bit, msb symbol in the top of the word
  function automatic logic [23:0] symbol_word(input logic [7:0] c);
    logic [23:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) w[3*k +: 3] = c[k] ? SYM_ONE : SYM_ZERO;
    return w;
  endfunction

  function automatic logic [7:0] dimmed(input logic [7:0] c, input led_item_t it);
    logic [8:0]  s;
    logic [16:0] prod;
    s = (it.scale > SCALE_FULL) ? SCALE_FULL : it.scale;
    prod = c * s;
    return it.use_scale ? prod[15:8] : c;
  endfunction

  function automatic void queue_spi_beats(input led_item_t it);
    logic [7:0] ch [3];
    logic       dark;
    spi_beat_t  b;
    case (it.cmd)
      CMD_PIXEL: begin
        dark = !it.lit || !strip_on;
        ch[0] = it.green;
        ch[1] = it.red;
        ch[2] = it.blue;
        for (int k = 0; k < 3; k++) begin
          b.word = symbol_word(dark ? 8'd0 : dimmed(ch[k], it));
          b.last = (k == 2);
          pending_beats.push_back(b);
        end
      end
      CMD_FRAME_START, CMD_FRAME_END: begin
        for (int k = 0; k < PAD_WORDS; k++) begin
          b.word = '0;
          b.last = (k == PAD_WORDS - 1);
          pending_beats.push_back(b);
        end
      end
      default: ;  // unused command is swallowed
    endcase
  endfunction

  function automatic led_item_t mk(input logic [1:0] c, input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic l, input logic u,
                                   input logic [8:0] s);
    led_item_t it;
    it.cmd = c;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.lit = l;
    it.use_scale = u;
    it.scale = s;
    return it;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic en, input led_item_t it,
                                  input logic typed, input logic [23:0] gw,
                                  input logic [23:0] rw, input logic [23:0] bw);
    table_row_t row;
    row.kind = kind;
    row.enable = en;
    row.item = it;
    row.typed = typed;
    row.typed_word[0] = gw;
    row.typed_word[1] = rw;
    row.typed_word[2] = bw;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [7:0] pick_color();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [8:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return SCALE_FULL;
      1: return 9'($urandom_range(257, 511));
      2: return 9'd0;
      default: return 9'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic led_item_t random_item();
    led_item_t it;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 72) it.cmd = CMD_PIXEL;
    else if (sel < 83) it.cmd = CMD_FRAME_START;
    else if (sel < 94) it.cmd = CMD_FRAME_END;
    else it.cmd = CMD_UNUSED;
    it.red = pick_color();
    it.green = pick_color();
    it.blue = pick_color();
    it.lit = ($urandom_range(0, 4) != 0);
    it.use_scale = 1'($urandom_range(0, 1));
    it.scale = pick_scale();
    return it;
  endfunction

  task automatic send_item(input led_item_t it);
    int unsigned gap;
    gap = sender_gap();
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= it.cmd;
    red <= it.red;
    green <= it.green;
    blue <= it.blue;
    lit <= it.lit;
    use_scale <= it.use_scale;
    scale <= it.scale;
    do @(posedge clk); while (full !== 1'b0);
    case (it.cmd)
      CMD_PIXEL: n_pixel++;
      CMD_FRAME_START, CMD_FRAME_END: n_pad++;
      default: n_dropped++;
    endcase
  endtask

  // wait for every beat to drain, plus slack for a dropped item still in the pipe
  task automatic drain();
    push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_strip_enable(input logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    strip_on = v;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_beat(input logic [23:0] w, input logic l);
    spi_beat_t want;
    beats_checked++;
    if (pending_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected beat: spi_word=%h last=%b", w, l);
    end else begin
      want = pending_beats.pop_front();
      if (w !== want.word || l !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat %0d mismatch: spi_word exp %h got %h, last exp %b got %b",
                   beats_checked, want.word, w, want.last, l);
        end
      end
    end
  endtask

  initial begin : result_side
    int unsigned gap;
    wait (rst == 1'b0);
    forever begin
      gap = receiver_gap();
      repeat (gap) begin
        pop <= 1'b0;
        @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      check_beat(spi_word, last);
    end
  end

  initial begin : stimulus
    led_item_t blank;
    spi_beat_t b;
    blank = mk(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 9'd0);

    // strip starts disabled, so pixels come out dark
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 0, 9'd256), 1,
            W_DARK, W_DARK, W_DARK);
    add_row(ROW_ITEM, 0, mk(CMD_FRAME_START, 8'h00, 8'h00, 8'h00, 0, 0, 9'd0), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'h12, 8'h34, 8'h56, 0, 1, 9'd100), 1,
            W_DARK, W_DARK, W_DARK);
    add_row(ROW_CFG, 1, blank, 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 0, 9'd0), 1,
            W_FULL, W_FULL, W_FULL);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1, 0, 9'd256), 1,
            W_DARK, W_DARK, W_DARK);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'h00, 8'hFF, 8'hFF, 1, 0, 9'd17), 1,
            W_FULL, W_DARK, W_FULL);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 0, 9'd256), 1,
            W_DARK, W_DARK, W_DARK);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hFF, 8'h80, 8'h01, 1, 1, 9'd256), 0, 0, 0, 0);
    // scale above full saturates
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hA5, 8'h5A, 8'hC3, 1, 1, 9'd511), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'h7E, 8'h81, 8'hFF, 1, 1, 9'd257), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 1, 9'd0), 1,
            W_DARK, W_DARK, W_DARK);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hFF, 8'h80, 8'h01, 1, 1, 9'd128), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hFF, 8'hFF, 8'h80, 1, 1, 9'd1), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_FRAME_END, 8'hFF, 8'hFF, 8'hFF, 1, 1, 9'd511), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_UNUSED, 8'hAA, 8'h55, 8'hFF, 1, 1, 9'd511), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'h55, 8'hAA, 8'h0F, 1, 1, 9'd200), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 0, 0, 9'd0), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_FRAME_START, 8'h00, 8'h00, 8'h00, 0, 0, 9'd0), 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 0, 9'd511), 1,
            W_FULL, W_FULL, W_FULL);
    add_row(ROW_CFG, 0, blank, 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, mk(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 1, 9'd256), 1,
            W_DARK, W_DARK, W_DARK);
    add_row(ROW_ITEM, 0, mk(CMD_FRAME_END, 8'h00, 8'h00, 8'h00, 0, 0, 9'd0), 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_strip_enable(dir_rows[i].enable);
      end else begin
        send_item(dir_rows[i].item);
        if (dir_rows[i].typed) begin
          for (int k = 0; k < 3; k++) begin
            b.word = dir_rows[i].typed_word[k];
            b.last = (k == 2);
            pending_beats.push_back(b);
          end
        end else begin
          queue_spi_beats(dir_rows[i].item);
        end
      end
    end

    // random phases: stalls on both sides, one side only, and none at all
    for (int p = 0; p < PHASES; p++) begin
      write_strip_enable((p % 3) != 1);
      quiet_tx = p[0];
      quiet_rx = p[1];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        blank = random_item();
        send_item(blank);
        queue_spi_beats(blank);
      end
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      mismatches++;
      $display("%0d beats never arrived", pending_beats.size());
    end
    $display("sent %0d pixels, %0d padding items, %0d unused commands; %0d enable writes",
             n_pixel, n_pad, n_dropped, cfg_writes);
    $display("checked %0d spi beats, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("** addressable_led_spi_frame_encoder: PASSED **");
    end else begin
      $display("** addressable_led_spi_frame_encoder: FAILED **");
    end
    $finish;
  end

endmodule
